/* hdl/pfs_pkg.sv */
// Package for the PLL factor search: constants, derived widths and shared types.
// No dependencies; every other file imports it.
package pfs_pkg;

    localparam int MAX_POSTDIV = 16;
    localparam int MAX_PREDIV  = 16;

    localparam int CLK_W   = 20;
    localparam int MULT_W  = 8;
    localparam int DIV_W   = 5;
    localparam int SHORT_W = 20;

    localparam int REF_KHZ     = 24000;
    localparam int VCO_MIN_KHZ = 192000;
    localparam int VCO_MAX_KHZ = 912000;
    localparam int MULT_MAX    = 128;

    localparam longint CLK_MAX = (longint'(1) << CLK_W) - 1;

    localparam int R_W    = $clog2(REF_KHZ);
    localparam int QC_W   = $clog2(CLK_MAX / REF_KHZ + 1);
    localparam int TGT_W  = $clog2(CLK_MAX * MAX_POSTDIV + 1);
    localparam int Q_W    = $clog2(CLK_MAX * MAX_POSTDIV / REF_KHZ + 1);
    localparam int M_W    = $clog2(MAX_PREDIV + 1);
    localparam int N_W    = Q_W + M_W + 1;
    localparam int K_MAX  = MAX_PREDIV * MAX_POSTDIV;
    localparam int K_W    = $clog2(K_MAX + 1);
    localparam int X_W    = $clog2(REF_KHZ + K_MAX);
    localparam int SH_W   = X_W + K_W;
    localparam int RCP_W  = SH_W + 1;
    localparam int SF_W   = R_W;
    localparam int P2     = 1 << $clog2(MAX_PREDIV);

    typedef struct packed {
        logic              have;
        logic [MULT_W-1:0] n;
        logic [DIV_W-1:0]  m;
        logic [DIV_W-1:0]  d;
        logic [SF_W-1:0]   sf;
    } t_best;

    typedef struct packed {
        logic [CLK_W-1:0] clk_khz;
        logic [QC_W-1:0]  qc;
        logic [R_W-1:0]   rc;
        logic [Q_W-1:0]   q;
        logic [R_W-1:0]   r;
        logic [TGT_W-1:0] tgt;
        t_best            best;
    } t_carry;

    typedef struct packed {
        logic              ok;
        logic [MULT_W-1:0] n;
        logic [SF_W-1:0]   sf;
    } t_lane_res;

    typedef struct packed {
        logic              ok;
        logic [MULT_W-1:0] n;
        logic [DIV_W-1:0]  m;
        logic [SF_W-1:0]   sf;
    } t_cand;

    typedef struct packed {
        logic [MULT_W-1:0]  mult;
        logic [DIV_W-1:0]   prediv;
        logic [DIV_W-1:0]   postdiv;
        logic [SHORT_W-1:0] shortfall;
        logic               found;
    } t_res;

endpackage

/* hdl/pfs_if.sv */
// Request and result channels of the PLL factor search, valid/ready handshake.
// Depends on pfs_pkg for field widths.
interface pfs_req_if import pfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] clk_khz;

    modport source (output valid, output clk_khz, input ready);
    modport sink (input valid, input clk_khz, output ready);
endinterface

interface pfs_res_if import pfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MULT_W-1:0]  best_mult;
    logic [DIV_W-1:0]   best_prediv;
    logic [DIV_W-1:0]   best_postdiv;
    logic [SHORT_W-1:0] shortfall_khz;
    logic               found;

    modport source (output valid, output best_mult, output best_prediv, output best_postdiv,
                    output shortfall_khz, output found, input ready);
    modport sink (input valid, input best_mult, input best_prediv, input best_postdiv,
                  input shortfall_khz, input found, output ready);
endinterface

/* hdl/pfs_lane.sv */
// One predivider lane of a post-divider cell: multiplier and remainder, then shortfall.
// Two register stages; depends on pfs_pkg.
module pfs_lane import pfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [M_W-1:0]   i_m,
    input  logic [K_W-1:0]   i_kmin1,
    input  logic [RCP_W-1:0] i_recip,
    input  logic [Q_W-1:0]   i_q,
    input  logic [R_W-1:0]   i_r,
    output t_lane_res        o_res
);

    localparam int RD_W = M_W + R_W;
    localparam int P_W  = X_W + RCP_W;

    logic [RD_W-1:0] w_rem;
    logic [M_W-1:0]  w_f;
    logic [N_W-1:0]  w_n;
    logic [N_W-1:0]  r_n;
    logic [R_W-1:0]  r_e;
    logic [X_W-1:0]  w_x;
    logic [P_W-1:0]  w_prod;
    t_lane_res       n_res;
    t_lane_res       r_res;

    always_comb begin
        w_rem = RD_W'(i_m) * RD_W'(i_r);
        w_f   = '0;
        for (int i = M_W - 1; i >= 0; i--) begin
            if (w_rem >= (RD_W'(REF_KHZ) << i)) begin
                w_rem  = w_rem - (RD_W'(REF_KHZ) << i);
                w_f[i] = 1'b1;
            end
        end
        w_n = N_W'(i_m) * N_W'(i_q) + N_W'(w_f);
    end

    // shortfall is the ceiling of remainder over m*d
    always_comb begin
        w_x       = X_W'(r_e) + X_W'(i_kmin1);
        w_prod    = P_W'(w_x) * P_W'(i_recip);
        n_res.ok  = (r_n != '0) && (r_n <= N_W'(MULT_MAX));
        n_res.n   = r_n[MULT_W-1:0];
        n_res.sf  = w_prod[SH_W +: SF_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= w_n;
            r_e   <= w_rem[R_W-1:0];
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* hdl/pll_factor_search.sv */
// PLL factor search top level: a chain of post-divider cells, each of three stages.
// A request passes the entry register, stages A, B and C of every cell, then the output register.
// Throughput: one request per cycle; a full output register and skid stall the chain.
// Reset clears the valid bits only; no clearing pass, results follow right after reset.
// Depends on pfs_pkg, pfs_if and pfs_lane.
module pll_factor_search import pfs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    pfs_req_if.sink   i_req,
    pfs_res_if.source o_res
);

    localparam int LAST = MAX_POSTDIV - 1;

    logic      w_en;
    logic      w_accept;
    logic      w_push;
    logic      w_pop;

    logic [CLK_W-1:0] w_drem;
    logic [QC_W-1:0]  w_dq;
    t_carry           n_c0;
    t_carry           r_c0;
    logic             r_v0;

    t_carry    w_cin  [MAX_POSTDIV];
    logic      w_vin  [MAX_POSTDIV];
    t_carry    r_cA   [MAX_POSTDIV];
    t_carry    r_cB   [MAX_POSTDIV];
    t_carry    r_cC   [MAX_POSTDIV];
    logic      r_vA   [MAX_POSTDIV];
    logic      r_vB   [MAX_POSTDIV];
    logic      r_vC   [MAX_POSTDIV];
    logic      r_winA [MAX_POSTDIV];
    logic      r_winB [MAX_POSTDIV];
    t_lane_res w_lres [MAX_POSTDIV][MAX_PREDIV];

    t_res w_res;
    t_res r_out;
    t_res n_out;
    t_res r_skid;
    t_res n_skid;
    logic r_out_v;
    logic n_out_v;
    logic r_skid_v;
    logic n_skid_v;

    assign w_en        = !(r_vC[LAST] && r_skid_v);
    assign i_req.ready = w_en;
    assign w_accept    = i_req.valid && w_en;

    // entry: split the request into quotient and remainder of the reference
    always_comb begin
        w_drem = i_req.clk_khz;
        w_dq   = '0;
        for (int i = QC_W - 1; i >= 0; i--) begin
            if (w_drem >= (CLK_W'(REF_KHZ) << i)) begin
                w_drem  = w_drem - (CLK_W'(REF_KHZ) << i);
                w_dq[i] = 1'b1;
            end
        end
        n_c0.clk_khz = i_req.clk_khz;
        n_c0.qc      = w_dq;
        n_c0.rc      = R_W'(w_drem);
        n_c0.q       = Q_W'(w_dq);
        n_c0.r       = R_W'(w_drem);
        n_c0.tgt     = TGT_W'(i_req.clk_khz);
        n_c0.best    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0 <= n_c0;
        end
    end

    for (genvar gd = 0; gd < MAX_POSTDIV; gd++) begin : g_div
        t_carry                w_step;
        logic [R_W:0]          w_rsum;
        logic                  w_wrap;
        logic                  w_win;
        t_cand                 w_node [2*P2-1];
        t_best                 w_best;
        t_carry                w_cout;

        if (gd == 0) begin : g_first
            assign w_cin[gd] = r_c0;
            assign w_vin[gd] = r_v0;
        end else begin : g_next
            assign w_cin[gd] = r_cC[gd-1];
            assign w_vin[gd] = r_vC[gd-1];
        end

        // stage A: window check, advance target to the next post divider
        always_comb begin
            w_rsum = (R_W+1)'(w_cin[gd].r) + (R_W+1)'(w_cin[gd].rc);
            w_wrap = w_rsum >= (R_W+1)'(REF_KHZ);
            w_step = w_cin[gd];
            if (w_wrap) begin
                w_step.r = R_W'(w_rsum - (R_W+1)'(REF_KHZ));
            end else begin
                w_step.r = R_W'(w_rsum);
            end
            w_step.q   = w_cin[gd].q + Q_W'(w_cin[gd].qc) + Q_W'(w_wrap);
            w_step.tgt = w_cin[gd].tgt + TGT_W'(w_cin[gd].clk_khz);
            w_win      = (w_cin[gd].tgt >= TGT_W'(VCO_MIN_KHZ))
                      && (w_cin[gd].tgt <= TGT_W'(VCO_MAX_KHZ));
        end

        for (genvar gm = 0; gm < MAX_PREDIV; gm++) begin : g_lane
            localparam int     K     = (gd + 1) * (gm + 1);
            localparam longint RECIP = ((longint'(1) << SH_W) + K - 1) / K;

            pfs_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_m     (M_W'(gm + 1)),
                .i_kmin1 (K_W'(K - 1)),
                .i_recip (RCP_W'(RECIP)),
                .i_q     (w_cin[gd].q),
                .i_r     (w_cin[gd].r),
                .o_res   (w_lres[gd][gm])
            );
        end

        // stage C: first smallest shortfall over the lanes, merged with the running best
        always_comb begin
            for (int j = 0; j < P2; j++) begin
                if (j < MAX_PREDIV) begin
                    w_node[P2-1+j].ok = r_winB[gd] && w_lres[gd][j].ok;
                    w_node[P2-1+j].n  = w_lres[gd][j].n;
                    w_node[P2-1+j].m  = DIV_W'(j + 1);
                    w_node[P2-1+j].sf = w_lres[gd][j].sf;
                end else begin
                    w_node[P2-1+j] = '0;
                end
            end
            for (int i = P2 - 2; i >= 0; i--) begin
                if (w_node[2*i+2].ok
                        && (!w_node[2*i+1].ok || w_node[2*i+2].sf < w_node[2*i+1].sf)) begin
                    w_node[i] = w_node[2*i+2];
                end else begin
                    w_node[i] = w_node[2*i+1];
                end
            end
            w_best = r_cB[gd].best;
            if (w_node[0].ok && (!w_best.have || w_node[0].sf < w_best.sf)) begin
                w_best.have = 1'b1;
                w_best.n    = w_node[0].n;
                w_best.m    = w_node[0].m;
                w_best.d    = DIV_W'(gd + 1);
                w_best.sf   = w_node[0].sf;
            end
            w_cout      = r_cB[gd];
            w_cout.best = w_best;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vA[gd] <= 1'b0;
                r_vB[gd] <= 1'b0;
                r_vC[gd] <= 1'b0;
            end else if (w_en) begin
                r_vA[gd] <= w_vin[gd];
                r_vB[gd] <= r_vA[gd];
                r_vC[gd] <= r_vB[gd];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cA[gd]      <= w_step;
                r_winA[gd]    <= w_win;
                r_cB[gd]      <= r_cA[gd];
                r_winB[gd]    <= r_winA[gd];
                r_cC[gd]      <= w_cout;
            end
        end
    end

    always_comb begin
        w_res.mult      = r_cC[LAST].best.n;
        w_res.prediv    = r_cC[LAST].best.m;
        w_res.postdiv   = r_cC[LAST].best.d;
        w_res.shortfall = SHORT_W'(r_cC[LAST].best.sf);
        w_res.found     = r_cC[LAST].best.have;
    end

    assign w_push = r_vC[LAST] && w_en;
    assign w_pop  = r_out_v && o_res.ready;

    // output register plus skid: hold a result while the next one drains from the chain
    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (w_pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else if (w_push) begin
                n_out = w_res;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v) begin
                n_out   = w_res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = w_res;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid         = r_out_v;
    assign o_res.best_mult     = r_out.mult;
    assign o_res.best_prediv   = r_out.prediv;
    assign o_res.best_postdiv  = r_out.postdiv;
    assign o_res.shortfall_khz = r_out.shortfall;
    assign o_res.found         = r_out.found;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while the output register is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vC[LAST] && !w_en) |=> (r_vC[LAST] && $stable(r_cC[LAST])))
        else $error("last cell lost or changed its result during a stall");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v0)
        else $error("accepted request did not enter the chain");

    a_none_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.best_mult == '0 && o_res.best_prediv == '0
            && o_res.best_postdiv == '0 && o_res.shortfall_khz == '0))
        else $error("result without a candidate carries non-zero fields");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.found) |-> (o_res.best_mult != '0
            && o_res.best_mult <= MULT_W'(MULT_MAX)
            && o_res.best_prediv != '0 && o_res.best_postdiv != '0))
        else $error("found result has factors outside their limits");

endmodule

/* dv/pll_factor_search_test.sv */
// Self-checking bench for pll_factor_search: a directed table, then random clock requests,
// with random gaps on the request side and random stalls on the result side.
// Depends on pfs_pkg, the pfs_req_if/pfs_res_if interfaces and the pll_factor_search RTL.
module pll_factor_search_test import pfs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int DRAIN_LIMIT     = 20000;
    localparam t_res NO_FIT        = '0;

    typedef struct {
        logic [CLK_W-1:0] khz;
        bit               typed;
        t_res             want;
    } t_plan_row;

    localparam int PLAN_LEN = 23;

    t_plan_row plan [PLAN_LEN] = '{
        '{20'd0,       1'b1, NO_FIT},
        '{20'd1,       1'b1, NO_FIT},
        '{20'd11999,   1'b1, NO_FIT},
        '{20'd12000,   1'b1, '{mult: 8'd8, prediv: 5'd1, postdiv: 5'd16,
                               shortfall: 20'd0, found: 1'b1}},
        '{20'd24000,   1'b1, '{mult: 8'd8, prediv: 5'd1, postdiv: 5'd8,
                               shortfall: 20'd0, found: 1'b1}},
        '{20'd192000,  1'b1, '{mult: 8'd8, prediv: 5'd1, postdiv: 5'd1,
                               shortfall: 20'd0, found: 1'b1}},
        '{20'd912000,  1'b1, '{mult: 8'd38, prediv: 5'd1, postdiv: 5'd1,
                               shortfall: 20'd0, found: 1'b1}},
        '{20'd912001,  1'b1, NO_FIT},
        '{20'd1000000, 1'b1, NO_FIT},
        '{20'hFFFFF,   1'b1, NO_FIT},
        '{20'd12001,   1'b0, NO_FIT},
        '{20'd911999,  1'b0, NO_FIT},
        '{20'd25175,   1'b0, NO_FIT},
        '{20'd27000,   1'b0, NO_FIT},
        '{20'd65000,   1'b0, NO_FIT},
        '{20'd74250,   1'b0, NO_FIT},
        '{20'd100003,  1'b0, NO_FIT},
        '{20'd148500,  1'b0, NO_FIT},
        '{20'd297000,  1'b0, NO_FIT},
        '{20'd456001,  1'b0, NO_FIT},
        '{20'd594000,  1'b0, NO_FIT},
        '{20'h55555,   1'b0, NO_FIT},
        '{20'hAAAAA,   1'b0, NO_FIT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfs_req_if req_ch ();
    pfs_res_if res_ch ();

    pll_factor_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_res factor_queue [$];
    bit   steady;
    int   mismatch_count;
    int   requests_sent;
    int   results_seen;
    int   fits_seen;

    always #5 i_clk = ~i_clk;

    function automatic t_res search_factors(input logic [CLK_W-1:0] khz);
        longint unsigned clk;
        longint unsigned tgt;
        longint unsigned mult;
        longint unsigned achieved;
        longint unsigned short_khz;
        longint unsigned best_short;
        bit              have;
        t_res            best;
        clk        = longint'(khz);
        best       = '0;
        best_short = 0;
        have       = 1'b0;
        for (int d = 1; d <= MAX_POSTDIV; d++) begin
            tgt = clk * longint'(d);
            if (tgt < VCO_MIN_KHZ || tgt > VCO_MAX_KHZ)
                continue;
            for (int m = 1; m <= MAX_PREDIV; m++) begin
                mult = (longint'(m) * tgt) / longint'(REF_KHZ);
                if (mult < 1 || mult > MULT_MAX)
                    continue;
                achieved  = ((longint'(REF_KHZ) * mult) / longint'(m)) / longint'(d);
                short_khz = clk - achieved;
                if (!have || short_khz < best_short) begin
                    have         = 1'b1;
                    best_short   = short_khz;
                    best.mult    = MULT_W'(mult);
                    best.prediv  = DIV_W'(m);
                    best.postdiv = DIV_W'(d);
                end
            end
        end
        best.shortfall = SHORT_W'(best_short);
        best.found     = have;
        return best;
    endfunction

    function automatic logic [CLK_W-1:0] random_clock();
        int pick;
        int d;
        int khz;
        pick = $urandom_range(0, 99);
        d    = $urandom_range(1, MAX_POSTDIV);
        if (pick < 70)
            khz = $urandom_range(VCO_MIN_KHZ / MAX_POSTDIV, VCO_MAX_KHZ);
        else if (pick < 78)
            khz = VCO_MIN_KHZ / d + $urandom_range(0, 4) - 2;
        else if (pick < 86)
            khz = VCO_MAX_KHZ / d + $urandom_range(0, 4) - 2;
        else if (pick < 92)
            khz = $urandom_range(0, VCO_MIN_KHZ / MAX_POSTDIV);
        else
            khz = $urandom;
        return CLK_W'(khz);
    endfunction

    task automatic send_request(input logic [CLK_W-1:0] khz, input t_res want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.clk_khz <= khz;
        do @(posedge i_clk); while (!req_ch.ready);
        factor_queue.push_back(want);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // result side: stall, then hold ready until a transfer
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (res_ch.found)
                fits_seen++;
            if (factor_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end else begin
                want = factor_queue.pop_front();
                if (res_ch.best_mult !== want.mult || res_ch.best_prediv !== want.prediv ||
                    res_ch.best_postdiv !== want.postdiv ||
                    res_ch.shortfall_khz !== want.shortfall || res_ch.found !== want.found)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch n/m/d/short/found expected %0d/%0d/%0d/%0d/%0d",
                                  " got %0d/%0d/%0d/%0d/%0d"}, $realtime,
                                 want.mult, want.prediv, want.postdiv, want.shortfall,
                                 want.found, res_ch.best_mult, res_ch.best_prediv,
                                 res_ch.best_postdiv, res_ch.shortfall_khz, res_ch.found);
                end
            end
        end
    end

    initial begin
        logic [CLK_W-1:0] khz;
        int               waited;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.clk_khz = '0;
        steady         = 1'b0;
        mismatch_count = 0;
        requests_sent  = 0;
        results_seen   = 0;
        fits_seen      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++)
            send_request(plan[i].khz, plan[i].typed ? plan[i].want : search_factors(plan[i].khz));

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            steady = ((i / 150) % 4) == 2;
            khz    = random_clock();
            send_request(khz, search_factors(khz));
        end
        req_ch.valid <= 1'b0;
        steady       = 1'b0;

        waited = 0;
        while (factor_queue.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (3 * MAX_POSTDIV + 16) @(posedge i_clk);
        if (factor_queue.size() > 0) begin
            $display("%0d requests never answered", factor_queue.size());
            mismatch_count += factor_queue.size();
        end

        $display("covered %0d clock requests (%0d table rows), %0d results, %0d with a fit",
                 requests_sent, PLAN_LEN, results_seen, fits_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timed out waiting on the search chain");
        $display("status: fail");
        $finish;
    end

endmodule

/* pll_factor_search.f */
hdl/pfs_pkg.sv
hdl/pfs_if.sv
hdl/pfs_lane.sv
hdl/pll_factor_search.sv
dv/pll_factor_search_test.sv
